FILE: design/focus_break_mood_machine_top_defines.svh
// Assertion macros used by the mood sequencer top level.
`ifndef FOCUS_BREAK_MOOD_MACHINE_TOP_DEFINES_SVH
`define FOCUS_BREAK_MOOD_MACHINE_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define FBMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define FBMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/fbmm_pkg.sv
// Package: word types, mood and command codes and register map of the mood sequencer.
`default_nettype none

package fbmm_pkg;

    // Register widths.
    localparam int unsigned WorkLimitW = 27;
    localparam int unsigned RestLenW   = 27;
    localparam int unsigned OverworkW  = 28;
    localparam int unsigned TimeoutW   = 20;
    localparam int unsigned IdleW      = 16;
    localparam int unsigned CfgDataW   = 28;
    localparam int unsigned CfgIndexW  = 3;

    // Internal counter widths; report age only needs to exceed any timeout.
    localparam int unsigned WorkW = 32;
    localparam int unsigned DtW   = 16;
    localparam int unsigned AgeW  = TimeoutW + 1;

    // Register reset values.
    localparam logic [WorkLimitW-1:0] WorkLimitRst = WorkLimitW'(30 * 60 * 1000);
    localparam logic [RestLenW-1:0]   RestLenRst   = RestLenW'(5 * 60 * 1000);
    localparam logic [OverworkW-1:0]  OverworkRst  = OverworkW'(35 * 60 * 1000);
    localparam logic [TimeoutW-1:0]   TimeoutRst   = TimeoutW'(8000);
    localparam logic [IdleW-1:0]      BusyIdleRst  = IdleW'(5);
    localparam logic [IdleW-1:0]      AwayIdleRst  = IdleW'(30);

    typedef enum logic [2:0] {
        MOOD_BOOT   = 3'd0,
        MOOD_ACTIVE = 3'd1,
        MOOD_SLEEPY = 3'd2,
        MOOD_DUE    = 3'd3,
        MOOD_BREAK  = 3'd4,
        MOOD_DONE   = 3'd5
    } t_mood;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_FORCE  = 2'd2,
        CMD_RESET  = 2'd3
    } t_cmd;

    typedef enum logic [CfgIndexW-1:0] {
        REG_WORK_LIMIT = 3'd0,
        REG_REST_LEN   = 3'd1,
        REG_OVERWORK   = 3'd2,
        REG_TIMEOUT    = 3'd3,
        REG_BUSY_IDLE  = 3'd4,
        REG_AWAY_IDLE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] dt_ms;
        logic        boot_pressed;
        logic [15:0] idle_seconds;
        logic        keyboard_active;
        logic        mouse_active;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  mood;
        logic [31:0] active_ms;
        logic [26:0] break_left_ms;
        logic        overworking;
        logic        linked;
        logic        in_use;
    } t_out_word;

endpackage

`default_nettype wire

FILE: design/focus_break_mood_machine_top.sv
// Top level of the work/break mood sequencer: input register, mood logic, result register.
//
//   channel   direction  handshake                    word
//   input     in         i_in_valid / o_in_stall      i_in_word  (fbmm_pkg::t_in_word)
//   result    out        o_out_valid / i_out_stall    o_out_word (fbmm_pkg::t_out_word)
//   config    in         i_cfg_we                     i_cfg_index, i_cfg_data
//
// One word is taken per clock cycle while o_in_stall is low; each accepted word goes into the
// input register, then makes the single pass through the mood logic into the result register.
// Reset is synchronous on i_rst_n; there is no clearing pass.
// A stalled result holds in the result register while one more word waits in the input
// register; only when both are full does o_in_stall rise.
`default_nettype none
`include "focus_break_mood_machine_top_defines.svh"

module focus_break_mood_machine_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire fbmm_pkg::t_in_word                 i_in_word,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output fbmm_pkg::t_out_word                     o_out_word,
    input  wire logic                               i_cfg_we,
    input  wire logic [fbmm_pkg::CfgIndexW-1:0]     i_cfg_index,
    input  wire logic [fbmm_pkg::CfgDataW-1:0]      i_cfg_data
);

    // Configuration registers.
    logic [fbmm_pkg::WorkLimitW-1:0] r_work_limit;
    logic [fbmm_pkg::RestLenW-1:0]   r_rest_len;
    logic [fbmm_pkg::OverworkW-1:0]  r_overwork;
    logic [fbmm_pkg::TimeoutW-1:0]   r_timeout;
    logic [fbmm_pkg::IdleW-1:0]      r_busy_idle;
    logic [fbmm_pkg::IdleW-1:0]      r_away_idle;

    // Input register and result register.
    logic               r_in_valid;
    fbmm_pkg::t_in_word r_in_word;
    logic               r_out_valid;
    fbmm_pkg::t_out_word r_out_word;
    fbmm_pkg::t_out_word n_out_word;
    logic               w_fire;
    logic               w_fire_report;

    // Sequencer state.
    fbmm_pkg::t_mood                 r_mood, n_mood;
    logic [fbmm_pkg::WorkW-1:0]      r_work, n_work;
    logic [fbmm_pkg::RestLenW-1:0]   r_rest, n_rest;
    logic                            r_over, n_over;
    logic                            r_link, n_link;
    logic [fbmm_pkg::AgeW-1:0]       r_age, n_age;
    logic [fbmm_pkg::IdleW-1:0]      r_idle, n_idle;
    logic                            r_kbd, n_kbd;
    logic                            r_mouse, n_mouse;

    // Intermediate values of a tick.
    logic [fbmm_pkg::WorkW:0]        w_work_sum;
    logic [fbmm_pkg::WorkW-1:0]      w_work_add;
    logic [fbmm_pkg::AgeW:0]         w_age_sum;
    logic [fbmm_pkg::AgeW-1:0]       w_age_add;
    logic [fbmm_pkg::RestLenW-1:0]   w_dt_wide;
    logic                            w_drop;
    logic                            w_link_t;
    logic                            w_kbd_t;
    logic                            w_mouse_t;
    logic                            w_busy;
    logic                            w_present;
    logic                            w_away;
    logic                            w_reached;
    logic                            w_rest_runs;
    logic                            w_pressed;

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work_limit <= fbmm_pkg::WorkLimitRst;
            r_rest_len   <= fbmm_pkg::RestLenRst;
            r_overwork   <= fbmm_pkg::OverworkRst;
            r_timeout    <= fbmm_pkg::TimeoutRst;
            r_busy_idle  <= fbmm_pkg::BusyIdleRst;
            r_away_idle  <= fbmm_pkg::AwayIdleRst;
        end else if (i_cfg_we) begin
            case (fbmm_pkg::t_reg_idx'(i_cfg_index))
                fbmm_pkg::REG_WORK_LIMIT: r_work_limit <= i_cfg_data[fbmm_pkg::WorkLimitW-1:0];
                fbmm_pkg::REG_REST_LEN:   r_rest_len   <= i_cfg_data[fbmm_pkg::RestLenW-1:0];
                fbmm_pkg::REG_OVERWORK:   r_overwork   <= i_cfg_data[fbmm_pkg::OverworkW-1:0];
                fbmm_pkg::REG_TIMEOUT:    r_timeout    <= i_cfg_data[fbmm_pkg::TimeoutW-1:0];
                fbmm_pkg::REG_BUSY_IDLE:  r_busy_idle  <= i_cfg_data[fbmm_pkg::IdleW-1:0];
                fbmm_pkg::REG_AWAY_IDLE:  r_away_idle  <= i_cfg_data[fbmm_pkg::IdleW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: a word moves on when the result register is empty or being drained.
    assign w_fire      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign w_fire_report = w_fire
                           && (fbmm_pkg::t_cmd'(r_in_word.command) == fbmm_pkg::CMD_REPORT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    // Saturating adds and link timeout as seen by a tick.
    always_comb begin
        w_pressed  = r_in_word.boot_pressed;
        w_work_sum = {1'b0, r_work} + {{(fbmm_pkg::WorkW+1-fbmm_pkg::DtW){1'b0}}, r_in_word.dt_ms};
        w_work_add = w_work_sum[fbmm_pkg::WorkW] ? {fbmm_pkg::WorkW{1'b1}}
                                                 : w_work_sum[fbmm_pkg::WorkW-1:0];
        w_age_sum  = {1'b0, r_age} + {{(fbmm_pkg::AgeW+1-fbmm_pkg::DtW){1'b0}}, r_in_word.dt_ms};
        w_age_add  = w_age_sum[fbmm_pkg::AgeW] ? {fbmm_pkg::AgeW{1'b1}}
                                               : w_age_sum[fbmm_pkg::AgeW-1:0];
        w_drop     = r_link && (w_age_add > {1'b0, r_timeout});
        w_link_t   = r_link && !w_drop;
        w_kbd_t    = r_kbd && !w_drop;
        w_mouse_t  = r_mouse && !w_drop;
        w_busy     = w_link_t && ((r_idle < r_busy_idle) || w_kbd_t || w_mouse_t);
        w_present  = w_link_t && (r_idle < r_away_idle);
        w_away     = w_link_t && (r_idle >= r_away_idle);
        w_dt_wide  = {{(fbmm_pkg::RestLenW-fbmm_pkg::DtW){1'b0}}, r_in_word.dt_ms};
        w_rest_runs = (r_rest > w_dt_wide);
        w_reached  = (w_work_add >= {{(fbmm_pkg::WorkW-fbmm_pkg::WorkLimitW){1'b0}}, r_work_limit});
    end

    // Next mood.
    always_comb begin
        n_mood = r_mood;
        case (fbmm_pkg::t_cmd'(r_in_word.command))
            fbmm_pkg::CMD_TICK: begin
                if (w_pressed) begin
                    n_mood = (r_mood == fbmm_pkg::MOOD_BREAK) ? fbmm_pkg::MOOD_ACTIVE
                                                              : fbmm_pkg::MOOD_BREAK;
                end else if (!w_link_t) begin
                    case (r_mood)
                        fbmm_pkg::MOOD_ACTIVE: begin
                            if (w_reached) n_mood = fbmm_pkg::MOOD_DUE;
                        end
                        fbmm_pkg::MOOD_DUE: begin
                        end
                        fbmm_pkg::MOOD_BREAK: begin
                            if (!w_rest_runs) n_mood = fbmm_pkg::MOOD_ACTIVE;
                        end
                        default: n_mood = fbmm_pkg::MOOD_ACTIVE;
                    endcase
                end else begin
                    case (r_mood)
                        fbmm_pkg::MOOD_ACTIVE: begin
                            // Going away wins over a break falling due.
                            if (w_away) begin
                                n_mood = fbmm_pkg::MOOD_SLEEPY;
                            end else if (w_busy && w_reached) begin
                                n_mood = fbmm_pkg::MOOD_DUE;
                            end
                        end
                        fbmm_pkg::MOOD_SLEEPY: begin
                            if (w_present) n_mood = fbmm_pkg::MOOD_ACTIVE;
                        end
                        fbmm_pkg::MOOD_DUE: begin
                        end
                        fbmm_pkg::MOOD_BREAK: begin
                            if (!w_rest_runs) n_mood = fbmm_pkg::MOOD_ACTIVE;
                        end
                        fbmm_pkg::MOOD_DONE: begin
                            if (w_busy) n_mood = fbmm_pkg::MOOD_ACTIVE;
                        end
                        default: n_mood = w_away ? fbmm_pkg::MOOD_SLEEPY : fbmm_pkg::MOOD_ACTIVE;
                    endcase
                end
            end
            fbmm_pkg::CMD_REPORT: n_mood = r_mood;
            fbmm_pkg::CMD_FORCE:  n_mood = fbmm_pkg::MOOD_DUE;
            default:              n_mood = fbmm_pkg::MOOD_BOOT;
        endcase
    end

    // Next work time, rest time, overwork flag and link state.
    always_comb begin
        n_work  = r_work;
        n_rest  = r_rest;
        n_over  = r_over;
        n_link  = r_link;
        n_age   = r_age;
        n_idle  = r_idle;
        n_kbd   = r_kbd;
        n_mouse = r_mouse;
        case (fbmm_pkg::t_cmd'(r_in_word.command))
            fbmm_pkg::CMD_TICK: begin
                n_age   = w_age_add;
                n_link  = w_link_t;
                n_kbd   = w_kbd_t;
                n_mouse = w_mouse_t;
                if (w_pressed) begin
                    if (r_mood == fbmm_pkg::MOOD_BREAK) begin
                        n_rest = '0;
                        n_work = '0;
                    end else begin
                        n_rest = r_rest_len;
                        n_over = 1'b0;
                    end
                end else begin
                    case (r_mood)
                        fbmm_pkg::MOOD_ACTIVE: begin
                            if (!w_link_t || w_busy) begin
                                n_work = w_work_add;
                                if (w_reached) n_over = 1'b0;
                            end
                        end
                        fbmm_pkg::MOOD_DUE: begin
                            if (!w_link_t || w_busy) n_work = w_work_add;
                            n_over = ({{(fbmm_pkg::WorkW-fbmm_pkg::OverworkW){1'b0}}, r_overwork}
                                      <= ((!w_link_t || w_busy) ? w_work_add : r_work));
                        end
                        fbmm_pkg::MOOD_BREAK: begin
                            if (w_rest_runs) begin
                                n_rest = r_rest - w_dt_wide;
                            end else begin
                                n_rest = '0;
                                n_work = '0;
                            end
                        end
                        fbmm_pkg::MOOD_SLEEPY: begin
                            if (!w_link_t) begin
                                n_work = '0;
                                n_rest = '0;
                                n_over = 1'b0;
                            end
                        end
                        fbmm_pkg::MOOD_DONE: begin
                            if (!w_link_t) begin
                                n_work = '0;
                                n_rest = '0;
                                n_over = 1'b0;
                            end else if (w_busy) begin
                                n_work = '0;
                            end
                        end
                        default: begin
                            // Leaving boot; the standalone loop also clears the rest time.
                            n_work = '0;
                            n_over = 1'b0;
                            if (!w_link_t) n_rest = '0;
                        end
                    endcase
                end
            end
            fbmm_pkg::CMD_REPORT: begin
                n_idle  = r_in_word.idle_seconds;
                n_kbd   = r_in_word.keyboard_active;
                n_mouse = r_in_word.mouse_active;
                n_age   = '0;
                n_link  = 1'b1;
            end
            fbmm_pkg::CMD_FORCE: begin
                n_work = {{(fbmm_pkg::WorkW-fbmm_pkg::WorkLimitW){1'b0}}, r_work_limit};
                n_over = 1'b0;
            end
            default: begin
                n_work = '0;
                n_rest = '0;
                n_over = 1'b0;
            end
        endcase
    end

    // Result word: the state after this word.
    always_comb begin
        n_out_word.mood          = n_mood;
        n_out_word.active_ms     = n_work;
        n_out_word.break_left_ms = n_rest;
        n_out_word.overworking   = n_over;
        n_out_word.linked        = n_link;
        n_out_word.in_use        = n_link && ((n_idle < r_busy_idle) || n_kbd || n_mouse);
    end

    // State update, one word per cycle whenever a word moves on (w_fire).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mood  <= fbmm_pkg::MOOD_BOOT;
            r_work  <= '0;
            r_rest  <= '0;
            r_over  <= 1'b0;
            r_link  <= 1'b0;
            r_age   <= '0;
            r_idle  <= '0;
            r_kbd   <= 1'b0;
            r_mouse <= 1'b0;
        end else if (w_fire) begin
            r_mood  <= n_mood;
            r_work  <= n_work;
            r_rest  <= n_rest;
            r_over  <= n_over;
            r_link  <= n_link;
            r_age   <= n_age;
            r_idle  <= n_idle;
            r_kbd   <= n_kbd;
            r_mouse <= n_mouse;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_word <= n_out_word;
        end
    end

    // Checks on the sequencer's own logic.
    `FBMM_ASSERT_NOW(a_stall_needs_word, o_in_stall, r_in_valid, "stall with empty input register")
    `FBMM_ASSERT_NEXT(a_fire_gives_result, w_fire, o_out_valid, "processed word gave no result")
    `FBMM_ASSERT_NOW(a_over_only_due, r_over, r_mood == fbmm_pkg::MOOD_DUE, "stray overwork flag")
    `FBMM_ASSERT_NEXT(a_report_links, w_fire_report, r_link, "report left the link down")

endmodule

`default_nettype wire

FILE: tb/mood_checker.sv
// Checker for the mood sequencer: watches all channels, predicts each result word and compares.
`timescale 1ns / 100ps

module mood_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  fbmm_pkg::t_in_word             i_in_word,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  fbmm_pkg::t_out_word            i_out_word,
    input  logic                           i_cfg_we,
    input  logic [fbmm_pkg::CfgIndexW-1:0] i_cfg_index,
    input  logic [fbmm_pkg::CfgDataW-1:0]  i_cfg_data,
    output int unsigned                    o_fail_count,
    output int unsigned                    o_pending
);

    import fbmm_pkg::*;

    // Register copies, held zero-extended to 32 bits.
    logic [31:0] lim_work, lim_rest, lim_over, lim_link, busy_thr, away_thr;

    // Predicted sequencer state.
    t_mood       mood_q;
    logic [31:0] work_ms, rest_ms, age_ms;
    logic        overwork_q, link_q, kbd_hold, mouse_hold;
    logic [15:0] idle_hold;

    t_out_word   mood_words_due[$];
    int unsigned fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic user_busy();
        return link_q && ((32'(idle_hold) < busy_thr) || kbd_hold || mouse_hold);
    endfunction

    // Rest countdown; when it runs out, work starts again from zero.
    function automatic void count_rest(input logic [31:0] dt);
        if (rest_ms > dt) begin
            rest_ms = rest_ms - dt;
        end else begin
            rest_ms = 0;
            work_ms = 0;
            mood_q  = MOOD_ACTIVE;
        end
    endfunction

    // Advances the predicted state by one input word and returns the result word.
    function automatic t_out_word step_mood(input t_in_word w);
        logic        busy, present, away;
        logic [31:0] dt;
        t_out_word   r;
        dt = 32'(w.dt_ms);
        case (t_cmd'(w.command))
            CMD_TICK: begin
                age_ms = add_sat(age_ms, dt);
                if (link_q && age_ms > lim_link) begin
                    link_q     = 1'b0;
                    kbd_hold   = 1'b0;
                    mouse_hold = 1'b0;
                end
                busy    = user_busy();
                present = link_q && (32'(idle_hold) < away_thr);
                away    = link_q && !(32'(idle_hold) < away_thr);
                if (w.boot_pressed) begin
                    // The button ends a rest, or starts one from any other mood.
                    if (mood_q == MOOD_BREAK) begin
                        rest_ms = 0;
                        work_ms = 0;
                        mood_q  = MOOD_ACTIVE;
                    end else begin
                        rest_ms    = lim_rest;
                        overwork_q = 1'b0;
                        mood_q     = MOOD_BREAK;
                    end
                end else if (!link_q) begin
                    // Standalone wall-clock loop.
                    case (mood_q)
                        MOOD_ACTIVE: begin
                            work_ms = add_sat(work_ms, dt);
                            if (work_ms >= lim_work) begin
                                overwork_q = 1'b0;
                                mood_q     = MOOD_DUE;
                            end
                        end
                        MOOD_DUE: begin
                            work_ms    = add_sat(work_ms, dt);
                            overwork_q = work_ms >= lim_over;
                        end
                        MOOD_BREAK: count_rest(dt);
                        default: begin
                            work_ms    = 0;
                            rest_ms    = 0;
                            overwork_q = 1'b0;
                            mood_q     = MOOD_ACTIVE;
                        end
                    endcase
                end else begin
                    // Linked: work counts only while busy, mood follows presence.
                    case (mood_q)
                        MOOD_ACTIVE: begin
                            if (busy) begin
                                work_ms = add_sat(work_ms, dt);
                                if (work_ms >= lim_work) begin
                                    overwork_q = 1'b0;
                                    mood_q     = MOOD_DUE;
                                end
                            end
                            // Going away wins over a break that just fell due.
                            if (away) mood_q = MOOD_SLEEPY;
                        end
                        MOOD_SLEEPY: begin
                            if (present) mood_q = MOOD_ACTIVE;
                        end
                        MOOD_DUE: begin
                            if (busy) work_ms = add_sat(work_ms, dt);
                            overwork_q = work_ms >= lim_over;
                        end
                        MOOD_BREAK: count_rest(dt);
                        MOOD_DONE: begin
                            if (busy) begin
                                work_ms = 0;
                                mood_q  = MOOD_ACTIVE;
                            end
                        end
                        default: begin
                            work_ms    = 0;
                            overwork_q = 1'b0;
                            mood_q     = away ? MOOD_SLEEPY : MOOD_ACTIVE;
                        end
                    endcase
                end
            end
            CMD_REPORT: begin
                idle_hold  = w.idle_seconds;
                kbd_hold   = w.keyboard_active;
                mouse_hold = w.mouse_active;
                age_ms     = 0;
                link_q     = 1'b1;
            end
            CMD_FORCE: begin
                work_ms    = lim_work;
                overwork_q = 1'b0;
                mood_q     = MOOD_DUE;
            end
            default: begin
                // Reset to boot keeps the link and the held report.
                work_ms    = 0;
                rest_ms    = 0;
                overwork_q = 1'b0;
                mood_q     = MOOD_BOOT;
            end
        endcase
        r.mood          = mood_q;
        r.active_ms     = work_ms;
        r.break_left_ms = rest_ms[26:0];
        r.overworking   = overwork_q;
        r.linked        = link_q;
        r.in_use        = user_busy();
        return r;
    endfunction

    task automatic check_word(input t_out_word got, input t_out_word want);
        if (got.mood !== want.mood) begin
            $error("mood mismatch: expected %0d, actual %0d", want.mood, got.mood);
            fails++;
        end
        if (got.active_ms !== want.active_ms) begin
            $error("active_ms mismatch: expected %0d, actual %0d",
                   want.active_ms, got.active_ms);
            fails++;
        end
        if (got.break_left_ms !== want.break_left_ms) begin
            $error("break_left_ms mismatch: expected %0d, actual %0d",
                   want.break_left_ms, got.break_left_ms);
            fails++;
        end
        if (got.overworking !== want.overworking) begin
            $error("overworking mismatch: expected %0b, actual %0b",
                   want.overworking, got.overworking);
            fails++;
        end
        if (got.linked !== want.linked) begin
            $error("linked mismatch: expected %0b, actual %0b", want.linked, got.linked);
            fails++;
        end
        if (got.in_use !== want.in_use) begin
            $error("in_use mismatch: expected %0b, actual %0b", want.in_use, got.in_use);
            fails++;
        end
    endtask

    // Register writes, prediction on each accepted word and comparison on each result.
    always @(posedge i_clk) begin
        t_out_word want_w;
        if (!i_rst_n) begin
            lim_work   = 32'(WorkLimitRst);
            lim_rest   = 32'(RestLenRst);
            lim_over   = 32'(OverworkRst);
            lim_link   = 32'(TimeoutRst);
            busy_thr   = 32'(BusyIdleRst);
            away_thr   = 32'(AwayIdleRst);
            mood_q     = MOOD_BOOT;
            work_ms    = 0;
            rest_ms    = 0;
            age_ms     = 0;
            overwork_q = 1'b0;
            link_q     = 1'b0;
            kbd_hold   = 1'b0;
            mouse_hold = 1'b0;
            idle_hold  = 0;
            mood_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_WORK_LIMIT: lim_work = 32'(i_cfg_data[WorkLimitW-1:0]);
                    REG_REST_LEN:   lim_rest = 32'(i_cfg_data[RestLenW-1:0]);
                    REG_OVERWORK:   lim_over = 32'(i_cfg_data[OverworkW-1:0]);
                    REG_TIMEOUT:    lim_link = 32'(i_cfg_data[TimeoutW-1:0]);
                    REG_BUSY_IDLE:  busy_thr = 32'(i_cfg_data[IdleW-1:0]);
                    REG_AWAY_IDLE:  away_thr = 32'(i_cfg_data[IdleW-1:0]);
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                mood_words_due.push_back(step_mood(i_in_word));
            end
            if (i_out_valid && !i_out_stall) begin
                if (mood_words_due.size() == 0) begin
                    $error("result word arrived with no expectation waiting");
                    fails++;
                end else begin
                    want_w = mood_words_due.pop_front();
                    check_word(i_out_word, want_w);
                end
            end
        end
        o_pending    <= mood_words_due.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the mood sequencer: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb;

    import fbmm_pkg::*;

    localparam int unsigned QuietLimit  = 1000;
    localparam int unsigned PhaseWords  = 225;
    localparam int unsigned PhaseCount  = 8;
    localparam int unsigned DueTicks    = 20;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_stall;
    t_in_word        in_word = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    t_out_word       out_word;
    logic            cfg_we = 1'b0;
    t_reg_idx        cfg_index = REG_WORK_LIMIT;
    logic [CfgDataW-1:0] cfg_data = '0;

    int unsigned     fail_count;
    int unsigned     pending;
    int unsigned     quiet_cycles = 0;
    int unsigned     stall_left = 0;
    int unsigned     cur_busy = 5;
    int unsigned     cur_away = 30;

    focus_break_mood_machine_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mood_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    // Result back-pressure: free stretches, short stalls and the odd long one.
    always @(posedge clk) begin
        int unsigned k;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            k = $urandom_range(0, 99);
            if (k < 10) begin
                out_stall  <= 1'b0;
                stall_left  = $urandom_range(30, 80);
            end else if (k < 50) begin
                out_stall  <= 1'b0;
                stall_left  = $urandom_range(0, 15);
            end else if (k < 92) begin
                out_stall  <= 1'b1;
                stall_left  = $urandom_range(0, 2);
            end else begin
                out_stall  <= 1'b1;
                stall_left  = $urandom_range(15, 50);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_word mk(input t_cmd cmd, input int unsigned dt, input logic pressed,
                                    input int unsigned idle, input logic kbd, input logic mouse);
        t_in_word w;
        w.command         = cmd;
        w.dt_ms           = 16'(dt);
        w.boot_pressed    = pressed;
        w.idle_seconds    = 16'(idle);
        w.keyboard_active = kbd;
        w.mouse_active    = mouse;
        return w;
    endfunction

    // Idle value within one second of a threshold.
    function automatic logic [15:0] near(input int unsigned thr);
        int v;
        v = int'(thr) + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    // Random word: all fields random, the fields that matter shaped towards the thresholds.
    function automatic t_in_word make_word();
        t_in_word    w;
        int unsigned k;
        w = t_in_word'({$urandom, $urandom});
        k = $urandom_range(0, 99);
        if (k < 62) begin
            w.command      = CMD_TICK;
            w.boot_pressed = ($urandom_range(0, 99) < 6);
            k = $urandom_range(0, 99);
            if (k < 8) w.dt_ms = 16'd0;
            else if (k < 14) w.dt_ms = 16'hFFFF;
            else if (k < 24) w.dt_ms = 16'($urandom);
            else w.dt_ms = 16'($urandom_range(1, 3000));
        end else if (k < 88) begin
            w.command         = CMD_REPORT;
            w.keyboard_active = ($urandom_range(0, 3) == 0);
            w.mouse_active    = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, 99);
            if (k < 35) w.idle_seconds = 16'($urandom_range(0, 40));
            else if (k < 50) w.idle_seconds = near(cur_busy);
            else if (k < 65) w.idle_seconds = near(cur_away);
            else w.idle_seconds = 16'($urandom);
        end else if (k < 94) begin
            w.command = CMD_FORCE;
        end else begin
            w.command = CMD_RESET;
        end
        return w;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 65) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Presents one word, holds it until it is taken, then idles for the given gap.
    task automatic send_word(input t_in_word w, input int unsigned gap);
        in_word  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the sender until every expected result has come, then lets the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CfgDataW-1:0] v0, input logic [CfgDataW-1:0] v1,
                                input logic [CfgDataW-1:0] v2, input logic [CfgDataW-1:0] v3,
                                input logic [CfgDataW-1:0] v4, input logic [CfgDataW-1:0] v5);
        logic [CfgDataW-1:0] vals [6];
        vals = '{v0, v1, v2, v3, v4, v5};
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= t_reg_idx'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        cur_busy  = v4[15:0];
        cur_away  = v5[15:0];
    endtask

    // Register value for a random phase: mostly a useful range, now and then raw data.
    function automatic logic [CfgDataW-1:0] pick(input logic raw_ok, input int unsigned lo,
                                                 input int unsigned hi);
        if (raw_ok && $urandom_range(0, 99) < 15) return CfgDataW'($urandom);
        return CfgDataW'($urandom_range(lo, hi));
    endfunction

    initial begin
        int unsigned wl;
        logic        raw_ok;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset settings: boot, button, rest, presence, timeout.
        send_word(mk(CMD_TICK, 0, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 65535, 0, 65535, 1, 1), gap_len());
        send_word(mk(CMD_REPORT, 65535, 1, 0, 1, 1), gap_len());
        send_word(mk(CMD_TICK, 0, 1, 0, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 65535, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 1, 1, 0, 0, 0), gap_len());
        send_word(mk(CMD_REPORT, 0, 0, 65535, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 100, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_REPORT, 0, 0, 29, 0, 1), gap_len());
        send_word(mk(CMD_TICK, 10, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_FORCE, 0, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 65535, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_RESET, 0, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 0, 0, 0, 0, 0), gap_len());

        // Low limits, always away: overwork, rest running out, and away beating break due.
        drain();
        program_regs(1000, 1000, 1000, 600000, 65535, 0);
        send_word(mk(CMD_RESET, 0, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_REPORT, 0, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 0, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_FORCE, 0, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 2000, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 0, 1, 0, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 1000, 0, 0, 0, 0), gap_len());
        send_word(mk(CMD_TICK, 1500, 0, 0, 0, 0), gap_len());

        // Random phases, each under its own register setting.
        for (int p = 0; p < PhaseCount; p++) begin
            drain();
            raw_ok = (p >= 4);
            case (p)
                1: program_regs(86400000, 86400000, 172800000, 600000, 65535, 65535);
                2: program_regs(1000, 1000, 1000, 1, 0, 0);
                3: program_regs('1, '1, '1, '1, '1, '1);
                default: begin
                    wl = $urandom_range(5000, 60000);
                    program_regs(raw_ok && $urandom_range(0, 99) < 15 ? CfgDataW'($urandom)
                                                                       : CfgDataW'(wl),
                                 pick(raw_ok, 2000, 30000),
                                 pick(raw_ok, wl, wl + 40000),
                                 pick(raw_ok, 1000, 20000),
                                 pick(raw_ok, 0, 20),
                                 pick(raw_ok, 10, 60));
                end
            endcase
            for (int n = 0; n < PhaseWords; n++) begin
                if (n == PhaseWords / 2) drain();
                send_word(make_word(), (n >= 40 && n < 80) ? 0 : gap_len());
            end
        end

        // Standalone break due under the largest ticks, then the button starts a rest.
        drain();
        program_regs(1000, 1000, '1, 1, 5, 30);
        send_word(mk(CMD_RESET, 0, 0, 0, 0, 0), 0);
        send_word(mk(CMD_TICK, 2, 0, 0, 0, 0), 0);
        send_word(mk(CMD_FORCE, 0, 0, 0, 0, 0), 0);
        for (int n = 0; n < DueTicks; n++) begin
            send_word(mk(CMD_TICK, 65535, 0, $urandom_range(0, 65535), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1))), 0);
        end
        send_word(mk(CMD_TICK, 0, 1, 0, 0, 0), 0);

        drain();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
